// ----- rtl/ffpa_pkg.sv -----
// Shared types and constants for the frame-from-point-and-axis block.
// No dependencies; imported by ffpa_norm and the top level.
package ffpa_pkg;

  // Working width of a difference vector component (33-bit signed plus margin)
  localparam int VEC_W = 34;

  typedef logic [2:0][31:0] fx3_t;
  typedef fx3_t [3:0]       rows_t;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef struct packed {
    logic               mode;
    logic [1:0]         axis_select;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] base_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] entry_a;
    logic signed [31:0] entry_b;
    logic signed [31:0] entry_c;
    logic signed [31:0] entry_d;
    logic               last_row;
  } out_word_t;

endpackage

// ----- rtl/ffpa_norm.sv -----
// Pipelined 3-vector normalizer: range shift, squares, bit-per-stage square root
// and bit-per-stage restoring division. Depends on ffpa_pkg.
module ffpa_norm #(
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [2:0][ffpa_pkg::VEC_W-1:0]   in_vec,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  output ffpa_pkg::fx3_t                    out_unit,
  output logic [SIDE_W-1:0]                 out_side
);
  import ffpa_pkg::*;

  localparam int POS_W    = $clog2(VEC_W);
  localparam int TOP_BIT  = 29;
  localparam int SQ_STEPS = 32;
  localparam int DV_STEPS = FRAC_BITS + 1;
  localparam int Q_W      = FRAC_BITS + 1;
  localparam int SQ0      = 6;
  localparam int SQ_LAST  = SQ0 + SQ_STEPS - 1;
  localparam int DV0      = SQ_LAST + 1;
  localparam int DV_LAST  = DV0 + DV_STEPS - 1;
  localparam int NS       = DV_LAST + 1;

  logic                    vld_r  [1:NS];
  logic [SIDE_W-1:0]       side_r [1:NS];
  logic [2:0]              neg_r  [1:DV_LAST];
  logic [2:0][VEC_W-1:0]   mag_r  [1:2];
  logic [VEC_W-1:0]        orv_r;
  logic [POS_W-1:0]        pos_r;
  logic [2:0][29:0]        m_r    [3:SQ_LAST];
  logic [2:0][59:0]        sqp_r;
  logic [61:0]             sum_r;
  logic [62:0]             rv_r   [SQ0:SQ_LAST];
  logic [62:0]             rr_r   [SQ0:SQ_LAST];
  logic [31:0]             len_r  [DV0:DV_LAST-1];
  logic [2:0][31:0]        rem_r  [DV0:DV_LAST-1];
  logic [2:0][Q_W-1:0]     q_r    [DV0:DV_LAST];
  fx3_t                    unit_r;

  logic [2:0]              neg_nxt;
  logic [2:0][VEC_W-1:0]   mag_nxt;
  logic [VEC_W-1:0]        orv_nxt;
  logic [POS_W-1:0]        pos_nxt;
  logic [2:0][29:0]        m_nxt;
  logic [2:0][59:0]        sqp_nxt;
  logic [61:0]             sum_nxt;
  logic [62:0]             sq_vin [0:SQ_STEPS-1];
  logic [62:0]             sq_rin [0:SQ_STEPS-1];
  logic [62:0]             rv_nxt [0:SQ_STEPS-1];
  logic [62:0]             rr_nxt [0:SQ_STEPS-1];
  logic [31:0]             dv_len [0:DV_STEPS-1];
  logic [2:0][32:0]        dv_t   [0:DV_STEPS-1];
  logic [2:0][Q_W-1:0]     dv_qin [0:DV_STEPS-1];
  logic [2:0][31:0]        rem_nxt[0:DV_STEPS-1];
  logic [2:0][Q_W-1:0]     q_nxt  [0:DV_STEPS-1];
  fx3_t                    unit_nxt;

  // magnitudes, leading-one position, range shift, squares, sum
  always_comb begin
    logic [VEC_W-1:0] sh;
    sh = '0;
    orv_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      neg_nxt[i] = in_vec[i][VEC_W-1];
      mag_nxt[i] = neg_nxt[i] ? (VEC_W'(0) - in_vec[i]) : in_vec[i];
      orv_nxt    = orv_nxt | mag_nxt[i];
    end
    pos_nxt = '0;
    for (int b = 0; b < VEC_W; b++) begin
      if (orv_r[b]) pos_nxt = POS_W'(b);
    end
    for (int i = 0; i < 3; i++) begin
      if (pos_r > POS_W'(TOP_BIT)) sh = mag_r[2][i] >> (pos_r - POS_W'(TOP_BIT));
      else sh = mag_r[2][i] << (POS_W'(TOP_BIT) - pos_r);
      m_nxt[i]   = sh[29:0];
      sqp_nxt[i] = 60'(m_r[3][i]) * 60'(m_r[3][i]);
    end
    sum_nxt = 62'(sqp_r[0]) + 62'(sqp_r[1]) + 62'(sqp_r[2]);
  end

  // square root: one result bit per stage
  always_comb begin
    logic [62:0] bitv, trial;
    sq_vin[0] = {1'b0, sum_r};
    sq_rin[0] = '0;
    for (int k = 1; k < SQ_STEPS; k++) begin
      sq_vin[k] = rv_r[SQ0+k-1];
      sq_rin[k] = rr_r[SQ0+k-1];
    end
    for (int k = 0; k < SQ_STEPS; k++) begin
      bitv  = 63'(1) << (62 - 2*k);
      trial = sq_rin[k] + bitv;
      if (sq_vin[k] >= trial) begin
        rv_nxt[k] = sq_vin[k] - trial;
        rr_nxt[k] = (sq_rin[k] >> 1) + bitv;
      end else begin
        rv_nxt[k] = sq_vin[k];
        rr_nxt[k] = sq_rin[k] >> 1;
      end
    end
  end

  // restoring division of each component by the length: one quotient bit per stage
  always_comb begin
    logic qb;
    dv_len[0] = rr_r[SQ_LAST][31:0];
    for (int i = 0; i < 3; i++) begin
      dv_t[0][i]   = 33'(m_r[SQ_LAST][i]);
      dv_qin[0][i] = '0;
    end
    for (int j = 1; j < DV_STEPS; j++) begin
      dv_len[j] = len_r[DV0+j-1];
      for (int i = 0; i < 3; i++) begin
        dv_t[j][i]   = {rem_r[DV0+j-1][i], 1'b0};
        dv_qin[j][i] = q_r[DV0+j-1][i];
      end
    end
    for (int j = 0; j < DV_STEPS; j++) begin
      for (int i = 0; i < 3; i++) begin
        qb = (dv_t[j][i] >= {1'b0, dv_len[j]});
        rem_nxt[j][i] = qb ? 32'(dv_t[j][i] - {1'b0, dv_len[j]}) : dv_t[j][i][31:0];
        q_nxt[j][i]   = {dv_qin[j][i][Q_W-2:0], qb};
      end
    end
    for (int i = 0; i < 3; i++) begin
      unit_nxt[i] = neg_r[DV_LAST][i] ? (32'd0 - 32'(q_r[DV_LAST][i]))
                                      : 32'(q_r[DV_LAST][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= NS; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_valid;
      for (int s = 2; s <= NS; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1] <= in_side;
      for (int s = 2; s <= NS; s++) side_r[s] <= side_r[s-1];
      neg_r[1] <= neg_nxt;
      for (int s = 2; s <= DV_LAST; s++) neg_r[s] <= neg_r[s-1];
      mag_r[1] <= mag_nxt;
      mag_r[2] <= mag_r[1];
      orv_r    <= orv_nxt;
      pos_r    <= pos_nxt;
      m_r[3]   <= m_nxt;
      for (int s = 4; s <= SQ_LAST; s++) m_r[s] <= m_r[s-1];
      sqp_r    <= sqp_nxt;
      sum_r    <= sum_nxt;
      for (int k = 0; k < SQ_STEPS; k++) begin
        rv_r[SQ0+k] <= rv_nxt[k];
        rr_r[SQ0+k] <= rr_nxt[k];
      end
      for (int j = 0; j < DV_STEPS; j++) begin
        q_r[DV0+j] <= q_nxt[j];
        if (j < DV_STEPS - 1) begin
          rem_r[DV0+j] <= rem_nxt[j];
          len_r[DV0+j] <= dv_len[j];
        end
      end
      unit_r <= unit_nxt;
    end
  end

  assign out_valid = vld_r[NS];
  assign out_side  = side_r[NS];
  assign out_unit  = unit_r;

endmodule

// ----- rtl/frame_from_point_and_axis_unit.sv -----
// Frame-from-point-and-axis top level: two normalizer pipelines, cross and dot
// product stages, and a four-row output serializer. Depends on ffpa_pkg, ffpa_norm.
//
// Each input word yields four output words, rows 0 to 3 of a 4x4 frame matrix,
// so under continuous load the block takes one input word per four output words,
// set by the output serializer that sends one row per cycle while out_ready is
// high. Internally the work is a fully pipelined chain (two normalizers of
// 39+FRAC_BITS stages each, then six product, rounding and assembly stages) that
// accepts a word in any cycle the chain is not held.
// The whole chain holds when its last stage is full and the serializer is busy.
module frame_from_point_and_axis_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffpa_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ffpa_pkg::out_word_t out_data
);
  import ffpa_pkg::*;

  localparam logic [31:0] ONE  = 32'(1) << FRAC_BITS;
  localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic  ident;
    axis_t ax;
    logic  mode;
    fx3_t  p;
    fx3_t  s;
  } side1_t;

  typedef struct packed {
    logic  ident;
    axis_t ax;
    fx3_t  p;
    fx3_t  va;
    logic  xyz;
  } side2_t;

  localparam int SIDE1_W = $bits(side1_t);
  localparam int SIDE2_W = $bits(side2_t);

  function automatic logic signed [63:0] fx_round(input logic signed [63:0] prod);
    logic [63:0] mag, sh;
    mag = prod[63] ? (64'd0 - prod) : prod;
    sh  = (mag + HALF) >> FRAC_BITS;
    return prod[63] ? -$signed(sh) : $signed(sh);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'h7fff_ffff;
    if (v < -66'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic fx3_t perm(input fx3_t v, input axis_t ax);
    case (ax)
      AXIS_Y:  return {v[1], v[0], v[2]};
      AXIS_Z:  return {v[0], v[2], v[1]};
      default: return v;
    endcase
  endfunction

  logic adv, load;

  // entry: difference vector and identity detection
  logic [2:0][VEC_W-1:0] d_vec;
  side1_t                s1_in, s1_out;
  logic                  n1_v;
  fx3_t                  n1_unit;
  logic                  zero_dir;

  always_comb begin
    d_vec[0] = VEC_W'(in_data.second_x) - VEC_W'(in_data.base_x);
    d_vec[1] = VEC_W'(in_data.second_y) - VEC_W'(in_data.base_y);
    d_vec[2] = VEC_W'(in_data.second_z) - VEC_W'(in_data.base_z);
    if (in_data.mode) zero_dir = (d_vec == '0);
    else zero_dir = (in_data.second_x == 0) && (in_data.second_y == 0)
                    && (in_data.second_z == 0);
    s1_in.ident = zero_dir || (axis_t'(in_data.axis_select) == AXIS_NONE);
    s1_in.ax    = axis_t'(in_data.axis_select);
    s1_in.mode  = in_data.mode;
    s1_in.p     = {in_data.base_z, in_data.base_y, in_data.base_x};
    s1_in.s     = {in_data.second_z, in_data.second_y, in_data.second_x};
  end

  ffpa_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE1_W)) u_norm_dir (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_valid),
    .in_vec   (d_vec),
    .in_side  (s1_in),
    .out_valid(n1_v),
    .out_unit (n1_unit),
    .out_side (s1_out)
  );

  // direction select, then normalize its horizontal part
  logic [2:0][VEC_W-1:0] h_vec;
  side2_t                s2_in, s2_out;
  logic                  n2_v;
  fx3_t                  n2_unit;

  always_comb begin
    s2_in.ident = s1_out.ident;
    s2_in.ax    = s1_out.ax;
    s2_in.p     = s1_out.p;
    s2_in.va    = s1_out.mode ? n1_unit : s1_out.s;
    s2_in.xyz   = (s2_in.va[0] == 0) && (s2_in.va[1] == 0);
    h_vec[0]    = VEC_W'($signed(s2_in.va[0]));
    h_vec[1]    = VEC_W'($signed(s2_in.va[1]));
    h_vec[2]    = '0;
  end

  ffpa_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE2_W)) u_norm_horz (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (n1_v),
    .in_vec   (h_vec),
    .in_side  (s2_in),
    .out_valid(n2_v),
    .out_unit (n2_unit),
    .out_side (s2_out)
  );

  // cross product and dot product stages
  logic x1_v_r, x2_v_r, y1_v_r, y2_v_r, y3_v_r, fin_v_r;
  logic x1_id_r, x2_id_r, y1_id_r, y2_id_r, y3_id_r;
  axis_t x1_ax_r, x2_ax_r, y1_ax_r, y2_ax_r, y3_ax_r;
  fx3_t x1_p_r, x2_p_r;
  fx3_t x1_va_r, x2_va_r, y1_va_r, y2_va_r, y3_va_r;
  fx3_t x1_vb_r, x2_vb_r, y1_vb_r, y2_vb_r, y3_vb_r;
  fx3_t x2_vc_r, y1_vc_r, y2_vc_r, y3_vc_r;
  fx3_t y3_vd_r;
  logic signed [63:0] x1_pr_r [4];
  logic signed [63:0] y1_pr_r [3][3];
  logic signed [63:0] y2_rp_r [3][3];
  rows_t fin_rows_r;

  fx3_t               vb_nxt, vc_nxt, vd_nxt;
  fx3_t               vsel [3];
  logic signed [63:0] x1_pr_nxt [4];
  logic signed [63:0] y1_pr_nxt [3][3];
  logic signed [63:0] y2_rp_nxt [3][3];
  rows_t              rows_nxt;

  always_comb begin
    vb_nxt[0] = s2_out.xyz ? ONE : (32'd0 - n2_unit[1]);
    vb_nxt[1] = s2_out.xyz ? 32'd0 : n2_unit[0];
    vb_nxt[2] = '0;
    x1_pr_nxt[0] = $signed(s2_out.va[2]) * $signed(vb_nxt[1]);
    x1_pr_nxt[1] = $signed(s2_out.va[2]) * $signed(vb_nxt[0]);
    x1_pr_nxt[2] = $signed(s2_out.va[0]) * $signed(vb_nxt[1]);
    x1_pr_nxt[3] = $signed(s2_out.va[1]) * $signed(vb_nxt[0]);

    vc_nxt[0] = sat32(-66'(fx_round(x1_pr_r[0])));
    vc_nxt[1] = sat32(66'(fx_round(x1_pr_r[1])));
    vc_nxt[2] = sat32(66'(fx_round(x1_pr_r[2])) - 66'(fx_round(x1_pr_r[3])));

    vsel[0] = x2_va_r;
    vsel[1] = x2_vb_r;
    vsel[2] = x2_vc_r;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        y1_pr_nxt[r][c] = $signed(vsel[r][c]) * $signed(x2_p_r[c]);
        y2_rp_nxt[r][c] = fx_round(y1_pr_r[r][c]);
      end
    end
    for (int r = 0; r < 3; r++) begin
      vd_nxt[r] = sat32(-(66'(y2_rp_r[r][0]) + 66'(y2_rp_r[r][1])
                          + 66'(y2_rp_r[r][2])));
    end

    if (y3_id_r) begin
      rows_nxt = '0;
      rows_nxt[0][0] = ONE;
      rows_nxt[1][1] = ONE;
      rows_nxt[2][2] = ONE;
    end else begin
      rows_nxt[0] = perm(y3_va_r, y3_ax_r);
      rows_nxt[1] = perm(y3_vb_r, y3_ax_r);
      rows_nxt[2] = perm(y3_vc_r, y3_ax_r);
      rows_nxt[3] = perm(y3_vd_r, y3_ax_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_v_r  <= 1'b0;
      x2_v_r  <= 1'b0;
      y1_v_r  <= 1'b0;
      y2_v_r  <= 1'b0;
      y3_v_r  <= 1'b0;
      fin_v_r <= 1'b0;
    end else if (adv) begin
      x1_v_r  <= n2_v;
      x2_v_r  <= x1_v_r;
      y1_v_r  <= x2_v_r;
      y2_v_r  <= y1_v_r;
      y3_v_r  <= y2_v_r;
      fin_v_r <= y3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_id_r <= s2_out.ident;
      x1_ax_r <= s2_out.ax;
      x1_p_r  <= s2_out.p;
      x1_va_r <= s2_out.va;
      x1_vb_r <= vb_nxt;
      x1_pr_r <= x1_pr_nxt;

      x2_id_r <= x1_id_r;
      x2_ax_r <= x1_ax_r;
      x2_p_r  <= x1_p_r;
      x2_va_r <= x1_va_r;
      x2_vb_r <= x1_vb_r;
      x2_vc_r <= vc_nxt;

      y1_id_r <= x2_id_r;
      y1_ax_r <= x2_ax_r;
      y1_va_r <= x2_va_r;
      y1_vb_r <= x2_vb_r;
      y1_vc_r <= x2_vc_r;
      y1_pr_r <= y1_pr_nxt;

      y2_id_r <= y1_id_r;
      y2_ax_r <= y1_ax_r;
      y2_va_r <= y1_va_r;
      y2_vb_r <= y1_vb_r;
      y2_vc_r <= y1_vc_r;
      y2_rp_r <= y2_rp_nxt;

      y3_id_r <= y2_id_r;
      y3_ax_r <= y2_ax_r;
      y3_va_r <= y2_va_r;
      y3_vb_r <= y2_vb_r;
      y3_vc_r <= y2_vc_r;
      y3_vd_r <= vd_nxt;

      fin_rows_r <= rows_nxt;
    end
  end

  // output serializer: one row per word
  logic       out_v_r;
  logic [1:0] row_r;
  rows_t      out_rows_r;

  assign load     = !out_v_r || (out_ready && (row_r == ROW_LAST));
  assign adv      = !fin_v_r || load;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      row_r   <= '0;
    end else if (load) begin
      out_v_r <= fin_v_r;
      row_r   <= '0;
    end else if (out_ready) begin
      row_r <= row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_rows_r <= fin_rows_r;
  end

  always_comb begin
    out_data.row_index = row_r;
    out_data.entry_a   = out_rows_r[row_r][0];
    out_data.entry_b   = out_rows_r[row_r][1];
    out_data.entry_c   = out_rows_r[row_r][2];
    out_data.entry_d   = (row_r == ROW_LAST) ? ONE : 32'd0;
    out_data.last_row  = (row_r == ROW_LAST);
  end

  assign out_valid = out_v_r;

endmodule

// ----- verif/tb_frame_from_point_and_axis_unit.sv -----
// Self-checking testbench for frame_from_point_and_axis_unit: a table of directed words,
// then random words, checked row by row against an in-bench frame predictor.
// Depends on ffpa_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_frame_from_point_and_axis_unit;
  import ffpa_pkg::*;

  localparam int  FRAC = 16;
  localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
  localparam int  RANDOM_WORDS = 215;
  localparam int  DRAIN_CYCLES = 2 * (40 + FRAC) + 30;
  localparam int  STALL_LIMIT  = 3000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  out_word_t frame_rows_q[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        ready_hold = 0;

  frame_from_point_and_axis_unit #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- frame predictor ----------------
  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p, m;
    p = a * b;
    m = (abs64(p) + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    return (p < 0) ? -m : m;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, bit_w;
    r = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= r + bit_w) begin
        v = v - (r + bit_w);
        r = (r >> 1) + bit_w;
      end else begin
        r >>= 1;
      end
      bit_w >>= 2;
    end
    return r;
  endfunction

  // v not all zero
  task automatic unit_vec(input longint v[3], output longint u[3]);
    longint unsigned m[3];
    longint unsigned big, sum, len, q;
    big = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = abs64(v[i]);
      if (m[i] > big) big = m[i];
    end
    while (big >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      big >>= 1;
    end
    while (big < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      big <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] << FRAC) / len;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
  endtask

  task automatic push_identity();
    out_word_t r;
    for (int k = 0; k < 4; k++) begin
      r.row_index = k[1:0];
      r.entry_a   = (k == 0) ? ONE_Q : '0;
      r.entry_b   = (k == 1) ? ONE_Q : '0;
      r.entry_c   = (k == 2) ? ONE_Q : '0;
      r.entry_d   = (k == 3) ? ONE_Q : '0;
      r.last_row  = (k[1:0] == ROW_LAST);
      frame_rows_q.push_back(r);
    end
  endtask

  task automatic predict_frame(input in_word_t w);
    longint p[3], s[3], d[3], va[3], vb[3], vc[3], vd[3], t[3], u[3];
    longint rows[4][4];
    int     col[3];
    bit     ident;
    out_word_t r;
    p = '{longint'(w.base_x), longint'(w.base_y), longint'(w.base_z)};
    s = '{longint'(w.second_x), longint'(w.second_y), longint'(w.second_z)};
    ident = 1'b0;
    if (w.mode) begin
      for (int i = 0; i < 3; i++) d[i] = s[i] - p[i];
      if (d[0] == 0 && d[1] == 0 && d[2] == 0) ident = 1'b1;
      else unit_vec(d, va);
    end else begin
      va = s;
      if (va[0] == 0 && va[1] == 0 && va[2] == 0) ident = 1'b1;
    end
    if (axis_t'(w.axis_select) == AXIS_NONE) ident = 1'b1;
    if (ident) begin
      push_identity();
      return;
    end
    if (va[0] != 0 || va[1] != 0) begin
      t = '{va[0], va[1], 0};
      unit_vec(t, u);
      vb = '{-u[1], u[0], 0};
    end else begin
      vb = '{longint'(ONE_Q), 0, 0};
    end
    vc[0] = sat32(qmul(va[1], vb[2]) - qmul(va[2], vb[1]));
    vc[1] = sat32(qmul(va[2], vb[0]) - qmul(va[0], vb[2]));
    vc[2] = sat32(qmul(va[0], vb[1]) - qmul(va[1], vb[0]));
    vd[0] = sat32(-(qmul(va[0], p[0]) + qmul(va[1], p[1]) + qmul(va[2], p[2])));
    vd[1] = sat32(-(qmul(vb[0], p[0]) + qmul(vb[1], p[1]) + qmul(vb[2], p[2])));
    vd[2] = sat32(-(qmul(vc[0], p[0]) + qmul(vc[1], p[1]) + qmul(vc[2], p[2])));
    case (axis_t'(w.axis_select))
      AXIS_Y:  col = '{2, 0, 1};
      AXIS_Z:  col = '{1, 2, 0};
      default: col = '{0, 1, 2};
    endcase
    for (int j = 0; j < 3; j++) begin
      rows[0][j] = va[col[j]];
      rows[1][j] = vb[col[j]];
      rows[2][j] = vc[col[j]];
      rows[3][j] = vd[col[j]];
    end
    for (int k = 0; k < 4; k++) rows[k][3] = (k == 3) ? longint'(ONE_Q) : 0;
    for (int k = 0; k < 4; k++) begin
      r.row_index = k[1:0];
      r.entry_a   = rows[k][0][31:0];
      r.entry_b   = rows[k][1][31:0];
      r.entry_c   = rows[k][2][31:0];
      r.entry_d   = rows[k][3][31:0];
      r.last_row  = (k[1:0] == ROW_LAST);
      frame_rows_q.push_back(r);
    end
  endtask

  // ---------------- stimulus ----------------
  typedef struct {
    bit       known_ident;
    in_word_t w;
  } dir_row_t;

  localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;

  dir_row_t dir_tab[] = '{
    '{1'b1, '{1'b0, AXIS_NONE, 32'sd5, -32'sd7, 32'sd9, 32'sd1, 32'sd2, 32'sd3}},
    '{1'b1, '{1'b0, AXIS_X, MAXV, MINV, MAXV, 32'sd0, 32'sd0, 32'sd0}},
    '{1'b1, '{1'b1, AXIS_Y, MINV, MAXV, -32'sd1, MINV, MAXV, -32'sd1}},
    '{1'b1, '{1'b0, AXIS_X, 32'sd0, 32'sd0, 32'sd0, ONE_Q, 32'sd0, 32'sd0}},
    '{1'b1, '{1'b1, AXIS_NONE, MINV, MINV, MINV, MAXV, MAXV, MAXV}},
    '{1'b0, '{1'b0, AXIS_X, 32'sd3, 32'sd4, 32'sd5, 32'sd0, 32'sd0, ONE_Q}},
    '{1'b0, '{1'b0, AXIS_Y, MAXV, MAXV, MAXV, 32'sd0, 32'sd0, MINV}},
    '{1'b0, '{1'b0, AXIS_Z, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}},
    '{1'b0, '{1'b0, AXIS_X, MINV, MINV, MINV, MINV, MINV, MINV}},
    '{1'b0, '{1'b0, AXIS_Y, MAXV, MINV, MAXV, MINV, MAXV, MINV}},
    '{1'b0, '{1'b1, AXIS_X, MINV, MINV, MINV, MAXV, MAXV, MAXV}},
    '{1'b0, '{1'b1, AXIS_Z, MAXV, MINV, 32'sd0, MINV, MAXV, 32'sd0}},
    '{1'b0, '{1'b1, AXIS_Y, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd1}},
    '{1'b0, '{1'b1, AXIS_X, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0}},
    '{1'b0, '{1'b0, AXIS_Z, 32'sd0, 32'sd0, 32'sd0, -32'sd1, 32'sd1, 32'sd1}}
  };

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? MAXV : MINV;
      2:       return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.mode        = 1'($urandom_range(0, 1));
    w.axis_select = ($urandom_range(0, 7) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
    w.base_x = rand_coord();
    w.base_y = rand_coord();
    w.base_z = rand_coord();
    w.second_x = rand_coord();
    w.second_y = rand_coord();
    w.second_z = rand_coord();
    // land on a zero difference now and then
    if (w.mode && $urandom_range(0, 15) == 0) begin
      w.second_x = w.base_x;
      w.second_y = w.base_y;
      w.second_z = w.base_z;
    end
    return w;
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_word(input in_word_t w, input bit known_ident);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (known_ident) push_identity();
    else predict_frame(w);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].known_ident);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // hold off until the pipeline has drained once, mid-run
      if (n == RANDOM_WORDS / 2) begin
        in_valid <= 1'b0;
        while (frame_rows_q.size() != 0) @(posedge clk);
      end
      send_word(rand_word(), 1'b0);
    end
    in_valid <= 1'b0;
    while (frame_rows_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // ---------------- result checking and back pressure ----------------
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (frame_rows_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row word: %p", out_data);
      end else begin
        exp_w = frame_rows_q.pop_front();
        if (out_data.row_index !== exp_w.row_index || out_data.entry_a !== exp_w.entry_a ||
            out_data.entry_b !== exp_w.entry_b || out_data.entry_c !== exp_w.entry_c ||
            out_data.entry_d !== exp_w.entry_d || out_data.last_row !== exp_w.last_row) begin
          mismatches++;
          if (mismatches <= 10) $display("row mismatch: exp %p got %p", exp_w, out_data);
        end
      end
    end
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : 0;
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
